// File: rtl/core/deque_with_running_sum_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the deque with running sum
// Short forms for clocked implication checks with a synchronous reset.
// ----------------------------------------------------------------------------
`ifndef DEQUE_WITH_RUNNING_SUM_ASSERT_SVH
`define DEQUE_WITH_RUNNING_SUM_ASSERT_SVH

// Same-cycle implication: when ante holds, cons must hold on the same edge.
`define DWRS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: when ante holds, cons must hold on the next edge.
`define DWRS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/dwrs_pkg.sv
// ----------------------------------------------------------------------------
// dwrs_pkg
// Shared types and constants of the deque with running sum.
// ----------------------------------------------------------------------------
package dwrs_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int DATA_W        = 32;
  localparam int CMD_W         = 3;
  localparam int STATUS_W      = 2;
  localparam int COUNT_OUT_W   = 5;
  localparam int M_TDATA_W     = 72;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_BACK  = 3'd1,
    CMD_REM_FRONT = 3'd2,
    CMD_REM_BACK  = 3'd3,
    CMD_CLEAR     = 3'd4
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE  = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

endpackage

// File: rtl/core/dwrs_ram.sv
// ----------------------------------------------------------------------------
// dwrs_ram
// Ring storage of the deque: one write port and one registered read port.
// ----------------------------------------------------------------------------
module dwrs_ram #(
  parameter int DEPTH = dwrs_pkg::DEPTH_DEFAULT
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [$clog2(DEPTH)-1:0]    waddr,
  input  logic [dwrs_pkg::DATA_W-1:0] wdata,
  input  logic                        re,
  input  logic [$clog2(DEPTH)-1:0]    raddr,
  output logic [dwrs_pkg::DATA_W-1:0] rdata
);

  logic [dwrs_pkg::DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/deque_with_running_sum.sv
// ----------------------------------------------------------------------------
// deque_with_running_sum
// Double-ended queue of 32-bit integers in a ring memory, with a running sum.
//
//   Channel  Dir  tdata                                   tuser
//   s_*      in   value[31:0]                             command[2:0]
//   m_*      out  removed_value, element_count, total_sum status[1:0]
//
// Inserts, clears, failed removes and unused commands load the result register
// directly; a successful remove first passes through ST_READ, as the ring read is registered.
// Reset clears the pointers, the count, the sum and the result valid flag;
// the ring contents are left as they are and are only read once written.
// A new word is taken when no remove is in flight and the result register
// is empty or being drained in the same cycle.
// ----------------------------------------------------------------------------
`include "deque_with_running_sum_assert.svh"

module deque_with_running_sum #(
  parameter int DEPTH = dwrs_pkg::DEPTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [dwrs_pkg::DATA_W-1:0]    s_tdata,   // [31:0] value
  input  logic [dwrs_pkg::CMD_W-1:0]     s_tuser,   // [2:0] command
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [31:0] removed_value, [36:32] element_count, [68:37] total_sum, [71:69] zero
  output logic [dwrs_pkg::M_TDATA_W-1:0] m_tdata,
  output logic [dwrs_pkg::STATUS_W-1:0]  m_tuser    // [1:0] status
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int DW = dwrs_pkg::DATA_W;
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_t;

  state_t          state, state_next;
  logic [AW-1:0]   head, head_next;
  logic [AW-1:0]   tail, tail_next;
  logic [CW-1:0]   count, count_next;
  logic [DW-1:0]   sum, sum_next;

  logic                              out_load;
  logic [DW-1:0]                     out_removed, out_removed_next;
  dwrs_pkg::status_t                 out_status, out_status_next;
  logic [dwrs_pkg::COUNT_OUT_W-1:0]  out_count;
  logic [DW-1:0]                     out_sum;

  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  logic [DW-1:0]   mem_rdata;

  logic            accept;
  logic            is_full, is_empty;
  logic [AW-1:0]   head_prev, head_succ, tail_prev, tail_succ;

  assign s_tready = (state == ST_IDLE) && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;
  assign is_full  = (count == FULL_CNT);
  assign is_empty = (count == '0);

  assign head_prev = (head == '0) ? LAST_IDX : head - AW'(1);
  assign head_succ = (head == LAST_IDX) ? '0 : head + AW'(1);
  assign tail_prev = (tail == '0) ? LAST_IDX : tail - AW'(1);
  assign tail_succ = (tail == LAST_IDX) ? '0 : tail + AW'(1);

  always_comb begin
    state_next       = state;
    head_next        = head;
    tail_next        = tail;
    count_next       = count;
    sum_next         = sum;
    out_load         = 1'b0;
    out_removed_next = '0;
    out_status_next  = dwrs_pkg::STAT_DONE;
    mem_we           = 1'b0;
    mem_waddr        = head_prev;
    mem_re           = 1'b0;
    mem_raddr        = head;

    if (state == ST_READ) begin
      // Read data of the remove issued last cycle; pointers and count moved then.
      out_load         = 1'b1;
      out_removed_next = mem_rdata;
      sum_next         = sum - mem_rdata;
      state_next       = ST_IDLE;
    end else if (accept) begin
      case (dwrs_pkg::cmd_t'(s_tuser))
        dwrs_pkg::CMD_INS_FRONT, dwrs_pkg::CMD_INS_BACK: begin
          out_load = 1'b1;
          if (is_full) begin
            out_status_next = dwrs_pkg::STAT_FULL;
          end else begin
            mem_we     = 1'b1;
            count_next = count + CW'(1);
            sum_next   = sum + s_tdata;
            if (s_tuser == dwrs_pkg::CMD_INS_FRONT) begin
              mem_waddr = head_prev;
              head_next = head_prev;
            end else begin
              mem_waddr = tail;
              tail_next = tail_succ;
            end
          end
        end
        dwrs_pkg::CMD_REM_FRONT, dwrs_pkg::CMD_REM_BACK: begin
          if (is_empty) begin
            out_load        = 1'b1;
            out_status_next = dwrs_pkg::STAT_EMPTY;
          end else begin
            mem_re     = 1'b1;
            count_next = count - CW'(1);
            state_next = ST_READ;
            if (s_tuser == dwrs_pkg::CMD_REM_FRONT) begin
              mem_raddr = head;
              head_next = head_succ;
            end else begin
              mem_raddr = tail_prev;
              tail_next = tail_prev;
            end
          end
        end
        dwrs_pkg::CMD_CLEAR: begin
          out_load   = 1'b1;
          head_next  = '0;
          tail_next  = '0;
          count_next = '0;
          sum_next   = '0;
        end
        default: begin
          out_load = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      head     <= '0;
      tail     <= '0;
      count    <= '0;
      sum      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
      sum   <= sum_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_removed <= out_removed_next;
      out_status  <= out_status_next;
      out_count   <= dwrs_pkg::COUNT_OUT_W'(count_next);
      out_sum     <= sum_next;
    end
  end

  assign m_tdata = {3'b000, out_sum, out_count, out_removed};
  assign m_tuser = out_status;

  dwrs_ram #(
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(s_tdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  `DWRS_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= FULL_CNT, "count above depth")
  `DWRS_ASSERT_NOW(a_no_take_in_read, clk, rst, state == ST_READ, !s_tready,
                   "word taken while a remove is in flight")
  `DWRS_ASSERT_NEXT(a_read_gives_result, clk, rst, state == ST_READ, m_tvalid,
                    "remove gave no result")
  `DWRS_ASSERT_NOW(a_full_status, clk, rst,
                   m_tvalid && (m_tuser == dwrs_pkg::STAT_FULL), is_full,
                   "full status while queue not full")

endmodule
